@@ rtl/bis_pkg.sv @@
// Shared types and fixed constants for the bilinear image sampler.
// No dependencies; imported by the sampler top level.
`timescale 1ns / 1ps
`default_nettype none

package bis_pkg;

  localparam int CH_W    = 16;   // one color channel, unsigned Q0.16
  localparam int NUM_CH  = 4;    // red, green, blue, alpha
  localparam int CFG_W   = 9;    // size register width
  localparam int COORD_W = 18;   // signed sample coordinate
  localparam int WPOS_W  = 8;    // write column / row width

  // Texel layout: channel 0 is red in the low bits, then green, blue, alpha.
  typedef logic [NUM_CH-1:0][CH_W-1:0] texel_t;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

endpackage

`default_nettype wire

@@ rtl/bilinear_image_sampler.sv @@
// Bilinear RGBA image sampler with clamp-to-edge addressing, five-stage pipeline.
// Depends on bis_pkg; texel store is four parity banks held in this module.
// Channel     | Signals                                       | Direction
// command     | start, busy, kind, write_*, sample_x, sample_y | in (busy out)
// result      | done, out_red, out_green, out_blue, out_alpha  | out
// config      | cfg_write, cfg_index, cfg_data                 | in
// One item is taken every cycle; busy is high only while rst is high.
// A sample result appears with done after stages 1 to 4 and the result register; writes give none.
// The texel store is split by column and row parity into four banks, so the four
// neighbors of a sample are read together, one read port per bank.
// rst clears valid bits and size registers; the store holds garbage until written.
// The receiver cannot stall, so nothing in the pipeline ever holds.
`timescale 1ns / 1ps
`default_nettype none

module bilinear_image_sampler
  import bis_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      kind,
  input  wire logic [WPOS_W-1:0]         write_col,
  input  wire logic [WPOS_W-1:0]         write_row,
  input  wire logic [CH_W-1:0]           write_red,
  input  wire logic [CH_W-1:0]           write_green,
  input  wire logic [CH_W-1:0]           write_blue,
  input  wire logic [CH_W-1:0]           write_alpha,
  input  wire logic signed [COORD_W-1:0] sample_x,
  input  wire logic signed [COORD_W-1:0] sample_y,
  output logic                           done,
  output logic [CH_W-1:0]                out_red,
  output logic [CH_W-1:0]                out_green,
  output logic [CH_W-1:0]                out_blue,
  output logic [CH_W-1:0]                out_alpha,
  input  wire logic                      cfg_write,
  input  wire logic                      cfg_index,
  input  wire logic [CFG_W-1:0]          cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int HCW   = (CW > 1) ? CW - 1 : 1;
  localparam int HRW   = (RW > 1) ? RW - 1 : 1;
  localparam int AW    = HCW + HRW;
  localparam int DEPTH = 1 << AW;
  localparam int SWX   = $clog2(MAX_WIDTH + 1);
  localparam int SWY   = $clog2(MAX_HEIGHT + 1);
  localparam int SWM   = (SWX > SWY) ? SWX : SWY;
  localparam int EW    = (SWM > CFG_W) ? SWM : CFG_W;
  localparam int IW    = COORD_W + 2;
  localparam int BW    = CH_W + FRAC_BITS + 2;

  localparam logic signed [IW-1:0] HALF_COORD = IW'(1 << (FRAC_BITS - 1));
  localparam logic [FRAC_BITS:0]   ONE_FIX    = (FRAC_BITS + 1)'(1 << FRAC_BITS);
  localparam logic [BW-1:0]        HALF_FIX   = BW'(1 << (FRAC_BITS - 1));

  function automatic logic signed [IW-1:0] clamp_idx(input logic signed [IW-1:0] i,
                                                     input logic signed [IW-1:0] lim);
    logic signed [IW-1:0] r;
    if (i < 0) begin
      r = '0;
    end else if (i > lim) begin
      r = lim;
    end else begin
      r = i;
    end
    return r;
  endfunction

  function automatic logic [CH_W-1:0] lerp(input logic [CH_W-1:0] a,
                                           input logic [CH_W-1:0] b,
                                           input logic [FRAC_BITS-1:0] f);
    logic [FRAC_BITS:0] g;
    logic [BW-1:0]      acc;
    g   = ONE_FIX - {1'b0, f};
    acc = BW'(a) * BW'(g) + BW'(b) * BW'(f) + HALF_FIX;
    return acc[FRAC_BITS +: CH_W];
  endfunction

  assign busy = rst;

  // Size registers
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_RESET;
      image_height <= SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [EW-1:0] w_eff;
  logic [EW-1:0] h_eff;

  always_comb begin
    w_eff = EW'(image_width);
    if (w_eff == '0) begin
      w_eff = EW'(1);
    end else if (w_eff > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end
    h_eff = EW'(image_height);
    if (h_eff == '0) begin
      h_eff = EW'(1);
    end else if (h_eff > EW'(MAX_HEIGHT)) begin
      h_eff = EW'(MAX_HEIGHT);
    end
  end

  // Stage 1: captured command
  logic                      s1_valid;
  logic                      s1_kind;
  logic [WPOS_W-1:0]         s1_col;
  logic [WPOS_W-1:0]         s1_row;
  texel_t                    s1_data;
  logic signed [COORD_W-1:0] s1_x;
  logic signed [COORD_W-1:0] s1_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_kind <= kind;
    s1_col  <= write_col;
    s1_row  <= write_row;
    s1_data <= {write_alpha, write_blue, write_green, write_red};
    s1_x    <= sample_x;
    s1_y    <= sample_y;
  end

  // Stage 1 logic: split coordinates, clamp neighbors
  logic signed [IW-1:0]  ux, uy, xi, yi, x0c, x1c, y0c, y1c, wlim, hlim;
  logic [CW-1:0]         c0_next, c1_next;
  logic [RW-1:0]         r0_next, r1_next;
  logic                  in_store;

  always_comb begin
    wlim = $signed(IW'(w_eff - EW'(1)));
    hlim = $signed(IW'(h_eff - EW'(1)));
    ux   = IW'(s1_x) - HALF_COORD;
    uy   = IW'(s1_y) - HALF_COORD;
    xi   = ux >>> FRAC_BITS;
    yi   = uy >>> FRAC_BITS;
    x0c  = clamp_idx(xi, wlim);
    x1c  = clamp_idx(xi + IW'(1), wlim);
    y0c  = clamp_idx(yi, hlim);
    y1c  = clamp_idx(yi + IW'(1), hlim);
    in_store = (32'(s1_col) < MAX_WIDTH) && (32'(s1_row) < MAX_HEIGHT);
    if (s1_kind == KIND_WRITE) begin
      // a write rides the c0/r0 slots to its bank
      c0_next = CW'(s1_col);
      c1_next = CW'(s1_col);
      r0_next = RW'(s1_row);
      r1_next = RW'(s1_row);
    end else begin
      c0_next = x0c[CW-1:0];
      c1_next = x1c[CW-1:0];
      r0_next = y0c[RW-1:0];
      r1_next = y1c[RW-1:0];
    end
  end

  // Stage 2: bank addressing, store access
  logic                 s2_valid;
  logic                 s2_kind;
  logic                 s2_in_store;
  logic [CW-1:0]        s2_c0, s2_c1;
  logic [RW-1:0]        s2_r0, s2_r1;
  logic [FRAC_BITS-1:0] s2_fx, s2_fy;
  texel_t               s2_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_kind     <= s1_kind;
    s2_in_store <= in_store;
    s2_c0       <= c0_next;
    s2_c1       <= c1_next;
    s2_r0       <= r0_next;
    s2_r1       <= r1_next;
    s2_fx       <= ux[FRAC_BITS-1:0];
    s2_fy       <= uy[FRAC_BITS-1:0];
    s2_data     <= s1_data;
  end

  logic [3:0]   bank_we;
  texel_t       bank_rd [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    texel_t        mem [DEPTH];
    texel_t        rd;
    logic [CW-1:0] col_sel;
    logic [RW-1:0] row_sel;
    logic [AW-1:0] addr;

    always_comb begin
      col_sel = (s2_c0[0] == b[0]) ? s2_c0 : s2_c1;
      row_sel = (s2_r0[0] == b[1]) ? s2_r0 : s2_r1;
      addr    = {HRW'(row_sel >> 1), HCW'(col_sel >> 1)};
    end

    assign bank_we[b] = s2_valid && (s2_kind == KIND_WRITE) && s2_in_store
                        && (s2_c0[0] == b[0]) && (s2_r0[0] == b[1]);

    always_ff @(posedge clk) begin
      if (bank_we[b]) begin
        mem[addr] <= s2_data;
      end
      rd <= mem[addr];
    end

    assign bank_rd[b] = rd;
  end

  // Stage 3: pick texels, blend along x
  logic                 s3_valid;
  logic [FRAC_BITS-1:0] s3_fx, s3_fy;
  logic                 s3_c0p, s3_c1p, s3_r0p, s3_r1p;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid && (s2_kind == KIND_SAMPLE);
    end
    s3_fx  <= s2_fx;
    s3_fy  <= s2_fy;
    s3_c0p <= s2_c0[0];
    s3_c1p <= s2_c1[0];
    s3_r0p <= s2_r0[0];
    s3_r1p <= s2_r1[0];
  end

  texel_t t00, t10, t01, t11;
  texel_t top_next, bot_next;

  always_comb begin
    t00 = bank_rd[{s3_r0p, s3_c0p}];
    t10 = bank_rd[{s3_r0p, s3_c1p}];
    t01 = bank_rd[{s3_r1p, s3_c0p}];
    t11 = bank_rd[{s3_r1p, s3_c1p}];
    for (int ch = 0; ch < NUM_CH; ch++) begin
      top_next[ch] = lerp(t00[ch], t10[ch], s3_fx);
      bot_next[ch] = lerp(t01[ch], t11[ch], s3_fx);
    end
  end

  // Stage 4: blend along y
  logic                 s4_valid;
  logic [FRAC_BITS-1:0] s4_fy;
  texel_t               s4_top, s4_bot;
  texel_t               color_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_fy  <= s3_fy;
    s4_top <= top_next;
    s4_bot <= bot_next;
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      color_next[ch] = lerp(s4_top[ch], s4_bot[ch], s4_fy);
    end
  end

  // Result register
  texel_t color;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4_valid;
    end
    color <= color_next;
  end

  assign out_red   = color[0];
  assign out_green = color[1];
  assign out_blue  = color[2];
  assign out_alpha = color[3];

  // Each sample transfer gives a result, and each result marks exactly one sample transfer.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == KIND_SAMPLE) |-> ##5 done)
    else $error("sample transfer produced no result");

  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && kind == KIND_SAMPLE, 5))
    else $error("result without a matching sample transfer");

  assert property (@(posedge clk) disable iff (rst) $onehot0(bank_we))
    else $error("write hit more than one bank");

  assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_kind == KIND_SAMPLE) |->
      (s2_c1 == s2_c0 || s2_c1 == CW'(s2_c0 + 1'b1)) &&
      (s2_r1 == s2_r0 || s2_r1 == RW'(s2_r0 + 1'b1)))
    else $error("neighbor indices not adjacent after clamp");

endmodule

`default_nettype wire
